// ===== design/smtc_pkg.sv =====
// shared types and constants for the skeleton model transform chain
// no dependencies; imported by the controller, datapath, top level and checker

package smtc_pkg;

   localparam int MAX_BONES   = 256;
   localparam int FRAC_BITS   = 16;

   localparam int BONE_W      = 8;
   localparam int CNT_W       = 9;
   localparam int VAL_W       = 32;
   localparam int MARK_W      = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;
   localparam int STORE_AW    = MARK_W + 4;
   localparam int LIM_W       = ($clog2(MAX_BONES + 1) > CNT_W) ? $clog2(MAX_BONES + 1) : CNT_W;
   localparam int PROD_W      = 2 * VAL_W;
   localparam int ACC_W       = PROD_W + 2;

   localparam int REQ_DATA_W  = 56;
   localparam int RSP_DATA_W  = 48;

   localparam logic [CNT_W-1:0] BONE_COUNT_RESET = CNT_W'(256);

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_BONE   = 2'd1,
      ST_PARENT = 2'd2
   } status_type;

   // controller to datapath
   typedef struct packed {
      logic       accept;
      logic       mac_issue;
      logic       emit_load;
      logic       err_load;
      logic [5:0] idx;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic       req_last;
      logic       req_has_parent;
      status_type req_err;
      logic       out_free;
      logic       pipe_busy;
   } sts_type;

endpackage

// ===== design/smtc_ctrl.sv =====
// sequencer for the transform chain: request intake, multiply-accumulate issue, result emission
// depends on smtc_pkg

module smtc_ctrl
   import smtc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_MAC,
      S_DRAIN,
      S_EMIT,
      S_ERR
   } state_type;

   state_type  state_ff;
   logic [5:0] cnt_ff;

   assign req_tready    = (state_ff == S_IDLE);
   assign cmd.accept    = req_tvalid && req_tready;
   assign cmd.mac_issue = (state_ff == S_MAC);
   assign cmd.emit_load = (state_ff == S_EMIT) && sts.out_free;
   assign cmd.err_load  = (state_ff == S_ERR) && sts.out_free;
   assign cmd.idx       = cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               cnt_ff <= '0;
               if (cmd.accept && sts.req_last) begin
                  priority if (sts.req_err != ST_OK) begin
                     state_ff <= S_ERR;
                  end else if (sts.req_has_parent) begin
                     state_ff <= S_MAC;
                  end else begin
                     state_ff <= S_EMIT;
                  end
               end
            end
            S_MAC: begin
               cnt_ff <= cnt_ff + 6'd1;
               if (cnt_ff == 6'd63) begin
                  state_ff <= S_DRAIN;
               end
            end
            S_DRAIN: begin
               cnt_ff <= '0;
               if (!sts.pipe_busy) begin
                  state_ff <= S_EMIT;
               end
            end
            S_EMIT: begin
               if (sts.out_free) begin
                  cnt_ff <= cnt_ff + 6'd1;
                  if (cnt_ff[3:0] == 4'd15) begin
                     state_ff <= S_IDLE;
                  end
               end
            end
            S_ERR: begin
               if (sts.out_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

// ===== design/smtc_datapath.sv =====
// datapath: local matrix buffer, model store, computed marks, mac pipeline, output register
// depends on smtc_pkg; driven by smtc_ctrl

module smtc_datapath
   import smtc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tuser,
   input  logic                  req_tlast,
   input  logic                  csr_wr_en,
   input  logic [CNT_W-1:0]      csr_wr_data,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [1:0]            rsp_tuser,
   output logic                  rsp_tlast,
   input  cmd_type               cmd,
   output sts_type               sts
);

   localparam logic signed [ACC_W-1:0] HALF   = ACC_W'(64'd1 << (FRAC_BITS - 1));
   localparam logic signed [ACC_W-1:0] SAT_HI =
      {{(ACC_W-VAL_W+1){1'b0}}, {(VAL_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] SAT_LO =
      {{(ACC_W-VAL_W+1){1'b1}}, {(VAL_W-1){1'b0}}};

   // request fields
   logic [BONE_W-1:0] in_bone;
   logic              in_has_parent;
   logic [BONE_W-1:0] in_parent;
   logic [3:0]        in_pos;
   logic [VAL_W-1:0]  in_value;

   assign in_bone       = req_tdata[7:0];
   assign in_has_parent = req_tdata[8];
   assign in_parent     = req_tdata[16:9];
   // row-major position: row above column
   assign in_pos        = {req_tdata[18:17], req_tdata[20:19]};
   assign in_value      = req_tdata[52:21];

   logic [CNT_W-1:0]  bone_cnt_ff;
   logic [MAX_BONES-1:0] mark_ff;
   logic [VAL_W-1:0]  loc_buf [16];
   logic [VAL_W-1:0]  res_buf [16];
   logic [VAL_W-1:0]  store   [1 << STORE_AW];

   logic [BONE_W-1:0] bone_ff;
   logic [BONE_W-1:0] parent_ff;
   logic              root_ff;

   // range and parent checks
   logic [LIM_W-1:0]  limit;
   logic              bone_ok;
   logic              parent_ok;
   status_type        req_err;

   assign limit = (LIM_W'(bone_cnt_ff) < LIM_W'(MAX_BONES)) ? LIM_W'(bone_cnt_ff)
                                                            : LIM_W'(MAX_BONES);
   assign bone_ok   = LIM_W'(in_bone) < limit;
   assign parent_ok = (LIM_W'(in_parent) < limit) && mark_ff[MARK_W'(in_parent)] && !req_tuser;

   always_comb begin
      priority if (!bone_ok) begin
         req_err = ST_BONE;
      end else if (in_has_parent && !parent_ok) begin
         req_err = ST_PARENT;
      end else begin
         req_err = ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bone_cnt_ff <= BONE_COUNT_RESET;
      end else if (csr_wr_en) begin
         bone_cnt_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mark_ff <= '0;
      end else if (cmd.accept) begin
         if (req_tlast && (req_err == ST_OK)) begin
            for (int b = 0; b < MAX_BONES; b++) begin
               mark_ff[b] <= (req_tuser ? 1'b0 : mark_ff[b])
                             || (MARK_W'(b) == MARK_W'(in_bone));
            end
         end else if (req_tuser) begin
            mark_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         loc_buf[in_pos] <= in_value;
         if (req_tlast) begin
            bone_ff   <= in_bone;
            parent_ff <= in_parent;
            root_ff   <= !in_has_parent;
         end
      end
   end

   // mac pipeline: read, multiply, accumulate, round and saturate
   logic [VAL_W-1:0]         st_rd_ff;
   logic [VAL_W-1:0]         loc_rd_ff;
   logic                     v1_ff, v2_ff, v3_ff;
   logic [1:0]               k1_ff, k2_ff;
   logic [3:0]               i1_ff, i2_ff, i3_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  prod_ext;
   logic signed [ACC_W-1:0]  rnd;
   logic signed [ACC_W-1:0]  shifted;
   logic [VAL_W-1:0]         sat_val;
   logic [VAL_W-1:0]         emit_val;

   assign prod_ext = {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
   assign rnd      = acc_ff + HALF;
   assign shifted  = rnd >>> FRAC_BITS;

   always_comb begin
      priority if (shifted > SAT_HI) begin
         sat_val = SAT_HI[VAL_W-1:0];
      end else if (shifted < SAT_LO) begin
         sat_val = SAT_LO[VAL_W-1:0];
      end else begin
         sat_val = shifted[VAL_W-1:0];
      end
   end

   assign emit_val = root_ff ? loc_buf[cmd.idx[3:0]] : res_buf[cmd.idx[3:0]];

   // model store: read parent rows while multiplying, write the bone's rows while emitting
   always_ff @(posedge clock) begin
      if (cmd.mac_issue) begin
         st_rd_ff <= store[{MARK_W'(parent_ff), cmd.idx[5:4], cmd.idx[1:0]}];
      end
      if (cmd.emit_load) begin
         store[{MARK_W'(bone_ff), cmd.idx[3:0]}] <= emit_val;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mac_issue) begin
         loc_rd_ff <= loc_buf[{cmd.idx[1:0], cmd.idx[3:2]}];
      end
      k1_ff   <= cmd.idx[1:0];
      i1_ff   <= cmd.idx[5:2];
      prod_ff <= $signed(st_rd_ff) * $signed(loc_rd_ff);
      k2_ff   <= k1_ff;
      i2_ff   <= i1_ff;
      if (v2_ff) begin
         acc_ff <= (k2_ff == 2'd0) ? prod_ext : acc_ff + prod_ext;
      end
      i3_ff <= i2_ff;
      if (v3_ff) begin
         res_buf[i3_ff] <= sat_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.mac_issue;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff && (k2_ff == 2'd3);
      end
   end

   // error kind of the latched request
   logic bone_ok_ff;

   always_ff @(posedge clock) begin
      if (cmd.accept && req_tlast) begin
         bone_ok_ff <= (req_err != ST_BONE);
      end
   end

   // output register
   logic                  out_vld_ff;
   logic [RSP_DATA_W-1:0] out_data_ff;
   status_type            out_status_ff;
   logic                  out_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (cmd.emit_load || cmd.err_load) begin
         out_vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_load) begin
         out_data_ff   <= {4'd0, emit_val, cmd.idx[1:0], cmd.idx[3:2], bone_ff};
         out_status_ff <= ST_OK;
         out_last_ff   <= (cmd.idx[3:0] == 4'd15);
      end else if (cmd.err_load) begin
         out_data_ff   <= {{(RSP_DATA_W-BONE_W){1'b0}}, bone_ff};
         out_status_ff <= (bone_ok_ff ? ST_PARENT : ST_BONE);
         out_last_ff   <= 1'b1;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_status_ff;
   assign rsp_tlast  = out_last_ff;

   assign sts.req_last       = req_tlast;
   assign sts.req_has_parent = in_has_parent;
   assign sts.req_err        = req_err;
   assign sts.out_free       = !out_vld_ff || rsp_tready;
   assign sts.pipe_busy      = v1_ff || v2_ff || v3_ff;

endmodule

// ===== design/skeleton_model_transform_chain.sv =====
// skeleton_model_transform_chain: forward kinematics over 4x4 q16.16 bone matrices.
// each request carries one element of a bone's local matrix; requests are taken only while idle.
// the request marked tlast closes the bone: a root's model matrix is its local matrix,
// any other bone gets parent model times local, with four exact 64-bit products per
// element, round half up at the binary point, then saturation to 32 bits. the sixteen
// elements come out row-major, the last one flagged with tlast. a bone out of range, or
// a parent out of range or not yet computed, gives one response with an error status.
// sequence: a root bone's closing request is followed by its sixteen responses; a child
// bone's closing request first runs 64 products through the single multiply-accumulate
// unit (one model store read per cycle), then waits for the pipeline to drain, then gives
// its sixteen responses. the last response waits in an output register while the next
// bone's elements are taken.
// depends on smtc_pkg, smtc_ctrl and smtc_datapath

module skeleton_model_transform_chain
   import smtc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // bone_index[7:0], has_parent[8], parent_index[16:9], element_row[18:17],
   // element_col[20:19], element_value[52:21], zero fill
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // start_pose
   input  logic                  req_tuser,
   // last_element
   input  logic                  req_tlast,
   // bone_count write
   input  logic                  csr_wr_en,
   input  logic [CNT_W-1:0]      csr_wr_data,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // out_bone[7:0], out_row[9:8], out_col[11:10], out_value[43:12], zero fill
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // status
   output logic [1:0]            rsp_tuser,
   // last_of_run
   output logic                  rsp_tlast
);

   cmd_type cmd;
   sts_type sts;

   // sequencer: owns the request handshake and all step counts
   smtc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // storage, checks, mac pipeline and response register
   smtc_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .cmd         (cmd),
      .sts         (sts)
   );

endmodule

// ===== design/smtc_checker.sv =====
// port-level checks for skeleton_model_transform_chain, bound to the top level
// depends on smtc_pkg

module smtc_checker
   import smtc_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [1:0]            rsp_tuser,
   input logic                  rsp_tlast
);

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // no response right after reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // an error response is a single zeroed response
   a_err_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != ST_OK) |-> rsp_tlast && (rsp_tdata[43:8] == 36'd0))
      else $error("malformed error response");

   // the closing response of a bone is element three, three
   a_last_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast && (rsp_tuser == ST_OK) |-> rsp_tdata[11:8] == 4'hf)
      else $error("matrix closed at wrong element");

   // no request is taken in the middle of a matrix
   a_no_req_mid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("request taken while responses pending");

endmodule

bind skeleton_model_transform_chain smtc_checker u_smtc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

// ===== bench/tb_skeleton_model_transform_chain.sv =====
`timescale 1ns / 100ps
// self-checking bench for skeleton_model_transform_chain: directed plan, then random bones
// depends on smtc_pkg and the design under design/

module tb_skeleton_model_transform_chain;
   import smtc_pkg::*;

   localparam int DRAIN_CYCLES = 8;     // settle time before a bone_count write
   localparam int END_CYCLES   = 40;    // quiet time after the last response
   localparam int PHASE_ITEMS  = 40;    // minimum requests per random phase
   localparam int NUM_PHASES   = 8;
   localparam int REPORT_MAX   = 10;
   localparam int PHASE_COUNTS [NUM_PHASES] = '{256, 40, 2, 511, 1, 129, 255, 256};

   // one request: one element of a bone's local matrix
   typedef struct packed {
      logic        start;
      logic [7:0]  bone;
      logic        has_par;
      logic [7:0]  par;
      logic [1:0]  row;
      logic [1:0]  col;
      logic [31:0] value;
      logic        last;
   } bone_elem_type;

   // one response: one model matrix element or an error
   typedef struct packed {
      logic [7:0]  bone;
      logic [1:0]  row;
      logic [1:0]  col;
      logic [31:0] value;
      status_type  status;
      logic        last;
   } model_elem_type;

   // directed plan row; cfg >= 0 writes bone_count first, typed rows carry their own answer
   typedef struct packed {
      int          cfg;
      bit          start;
      int          bone;
      bit          has_par;
      int          par;
      int          pos;
      logic [31:0] value;
      bit          last;
      bit          typed;
      status_type  want;
   } plan_row_type;

   plan_row_type plan [28] = '{
      // first root fills the whole local buffer, value extremes included
      '{-1, 1,   0, 0, 255,  0, 32'h7fffffff, 0, 0, ST_OK},
      '{-1, 0,   0, 0, 255,  1, 32'h80000000, 0, 0, ST_OK},
      '{-1, 0,   0, 0, 255,  2, 32'h00000000, 0, 0, ST_OK},
      '{-1, 0,   0, 0, 255,  3, 32'h00010000, 0, 0, ST_OK},
      '{-1, 0,   0, 0, 255,  4, 32'hffffffff, 0, 0, ST_OK},
      '{-1, 0,   0, 0, 255,  5, 32'h00008000, 0, 0, ST_OK},
      '{-1, 0,   0, 0, 255,  6, 32'hffff8000, 0, 0, ST_OK},
      '{-1, 0,   0, 0, 255,  7, 32'h00000001, 0, 0, ST_OK},
      '{-1, 0,   0, 0, 255,  8, 32'h7fff0000, 0, 0, ST_OK},
      '{-1, 0,   0, 0, 255,  9, 32'h80010000, 0, 0, ST_OK},
      '{-1, 0,   0, 0, 255, 10, 32'h00020000, 0, 0, ST_OK},
      '{-1, 0,   0, 0, 255, 11, 32'hfffe0000, 0, 0, ST_OK},
      '{-1, 0,   0, 0, 255, 12, 32'h12345678, 0, 0, ST_OK},
      '{-1, 0,   0, 0, 255, 13, 32'hedcba988, 0, 0, ST_OK},
      '{-1, 0,   0, 0, 255, 14, 32'h00010000, 0, 0, ST_OK},
      '{-1, 0,   0, 0, 255, 15, 32'h55555555, 1, 0, ST_OK},
      // child of the extreme root: saturates both ways
      '{-1, 0,   1, 1,   0,  0, 32'h00010000, 1, 0, ST_OK},
      // highest bone as a root, then as a parent
      '{-1, 0, 255, 0, 255,  5, 32'h00000000, 1, 0, ST_OK},
      '{-1, 0,   2, 1, 255, 15, 32'h80000000, 1, 0, ST_OK},
      // own parent, already computed
      '{-1, 0,   1, 1,   1,  6, 32'h00000000, 1, 0, ST_OK},
      // own parent, never computed
      '{-1, 0,   3, 1,   3,  0, 32'h00010000, 1, 1, ST_PARENT},
      // start of pose wipes the marks, so bone 0 is no parent any more
      '{-1, 1,   2, 1,   0,  0, 32'h00010000, 1, 1, ST_PARENT},
      // smallest skeleton: only bone 0 exists
      '{ 1, 0,   1, 0,   0,  0, 32'h00010000, 1, 1, ST_BONE},
      '{-1, 0,   0, 0,   0,  0, 32'h00010000, 1, 0, ST_OK},
      '{-1, 0,   0, 1, 200,  0, 32'h00010000, 1, 1, ST_PARENT},
      '{-1, 0,   0, 1,   0,  3, 32'h00030000, 1, 0, ST_OK},
      // empty skeleton: everything out of range
      '{ 0, 0,   0, 0,   0,  0, 32'h00010000, 1, 1, ST_BONE},
      // back to full size, child of a bone computed under the old count
      '{256, 0, 255, 1,  0,  9, 32'hfff00000, 1, 0, ST_OK}
   };

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata   = '0;
   logic                  req_tuser   = 1'b0;
   logic                  req_tlast   = 1'b0;
   logic                  csr_wr_en   = 1'b0;
   logic [CNT_W-1:0]      csr_wr_data = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [1:0]            rsp_tuser;
   logic                  rsp_tlast;

   // predictor state: own copy of the register, local buffer, model store and marks
   logic [CNT_W-1:0]    bone_count_reg = BONE_COUNT_RESET;
   logic signed [31:0]  local_elems [16];
   logic signed [31:0]  model_mats [MAX_BONES][16];
   bit                  bone_done [MAX_BONES];

   model_elem_type model_elems_due [$];    // expected responses, oldest first

   int send_idle_pct = 0;
   int stall_pct     = 0;
   int errors        = 0;
   int n_requests    = 0;
   int n_responses   = 0;
   int n_err_resp    = 0;
   int n_settings    = 0;
   int bones_sent    = 0;

   skeleton_model_transform_chain DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #6 clock = ~clock;

   // worst case is far below this: ~410 requests under full stress
   initial begin
      #8_000_000;
      $display("tb_skeleton_model_transform_chain: errors");
      $finish;
   end

   function automatic void log_error(input string msg);
      errors++;
      if (errors <= REPORT_MAX)
         $display("%t  %s", $realtime, msg);
   endfunction

   function automatic model_elem_type err_elem(input logic [7:0] b, input status_type s);
      err_elem = '{bone: b, row: 2'd0, col: 2'd0, value: 32'd0, status: s, last: 1'b1};
   endfunction

   // one element of parent * local: exact products, round half up, saturate
   function automatic logic [31:0] fk_dot(input int p, input int r, input int c);
      logic signed [65:0] acc;
      longint prod;
      acc = '0;
      for (int k = 0; k < 4; k++) begin
         prod = longint'(model_mats[p][r*4+k]) * longint'(local_elems[k*4+c]);
         acc  += prod;
      end
      acc += 66'sd1 <<< (FRAC_BITS - 1);
      acc = acc >>> FRAC_BITS;
      if (acc > 66'sd2147483647)
         return 32'h7fffffff;
      if (acc < -66'sd2147483648)
         return 32'h80000000;
      return acc[31:0];
   endfunction

   // forward kinematics step for one accepted request
   function automatic void fk_step(input bone_elem_type e, ref model_elem_type outq[$]);
      int lim;
      int pos;
      logic signed [31:0] fresh [16];
      pos = {e.row, e.col};
      if (e.start)
         bone_done = '{default: 1'b0};
      local_elems[pos] = e.value;
      if (!e.last)
         return;
      lim = (bone_count_reg < MAX_BONES) ? int'(bone_count_reg) : MAX_BONES;
      if (e.bone >= lim) begin
         outq.push_back(err_elem(e.bone, ST_BONE));
         return;
      end
      if (e.has_par) begin
         if (e.par >= lim || !bone_done[e.par]) begin
            outq.push_back(err_elem(e.bone, ST_PARENT));
            return;
         end
         // all sixteen from the old parent matrix first, so a bone may be its own parent
         for (int i = 0; i < 16; i++)
            fresh[i] = fk_dot(e.par, i >> 2, i & 3);
      end else begin
         fresh = local_elems;
      end
      for (int i = 0; i < 16; i++) begin
         model_mats[e.bone][i] = fresh[i];
         outq.push_back('{bone: e.bone, row: 2'(i >> 2), col: 2'(i & 3), value: fresh[i],
                          status: ST_OK, last: (i == 15)});
      end
      bone_done[e.bone] = 1'b1;
   endfunction

   // offer one request, wait for the handshake, then predict its responses
   task automatic send_request(input bone_elem_type e, input bit typed,
                               input status_type want);
      model_elem_type got [$];
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {3'b000, e.value, e.col, e.row, e.par, e.has_par, e.bone};
      req_tuser  <= e.start;
      req_tlast  <= e.last;
      do @(posedge clock); while (!req_tready);
      n_requests++;
      fk_step(e, got);
      // error rows of the plan carry their answer directly
      if (typed && e.last) begin
         got = {};
         got.push_back(err_elem(e.bone, want));
      end
      foreach (got[i])
         model_elems_due.push_back(got[i]);
   endtask

   // hold off the sender until nothing is pending, then let the block go quiet
   task automatic drain_results(input int extra);
      req_tvalid <= 1'b0;
      while (model_elems_due.size() != 0)
         @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_bone_count(input int v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= CNT_W'(v);
      @(posedge clock);
      csr_wr_en      <= 1'b0;
      bone_count_reg = CNT_W'(v);
      n_settings++;
   endtask

   function automatic logic [31:0] rand_q16();
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 4))
               0: return 32'h7fffffff;
               1: return 32'h80000000;
               2: return 32'h00000000;
               3: return 32'hffffffff;
               default: return 32'h00010000;
            endcase
         end
         1, 2, 3: return $urandom;
         // typical transform entries, around plus or minus two
         default: return 32'($urandom_range(0, 1 << 18)) - 32'(1 << 17);
      endcase
   endfunction

   // one bone: mostly a well-formed matrix under a computed parent, sometimes noise
   task automatic random_bone();
      int lim;
      int n;
      int pos;
      int order [16];
      int cands [$];
      int tmp;
      int j;
      bit first_start;
      bit ends;
      bone_elem_type e;
      // sender pause until every expected response is in
      if (bones_sent == 5 || $urandom_range(0, 99) < 3)
         drain_results(0);
      bones_sent++;
      lim = (bone_count_reg < MAX_BONES) ? int'(bone_count_reg) : MAX_BONES;
      ends = 1'b1;
      e = '0;
      if ($urandom_range(0, 99) < 80 && lim > 0) begin
         e.bone = 8'($urandom_range(0, lim - 1));
         for (int b = 0; b < lim; b++)
            if (bone_done[b])
               cands.push_back(b);
         e.has_par = cands.size() > 0 && $urandom_range(0, 99) < 70;
         e.par = e.has_par ? 8'(cands[$urandom_range(0, cands.size() - 1)])
                           : 8'($urandom_range(0, 255));
         n = ($urandom_range(0, 99) < 80) ? 16 : $urandom_range(1, 4);
         first_start = !e.has_par && $urandom_range(0, 99) < 8;
      end else begin
         // noise: any index, any parent, often a broken or abandoned matrix
         e.bone      = 8'($urandom_range(0, 255));
         e.has_par   = $urandom_range(0, 1);
         e.par       = 8'($urandom_range(0, 255));
         n           = $urandom_range(1, 3);
         first_start = $urandom_range(0, 99) < 10;
         ends        = $urandom_range(0, 99) < 75;
      end
      for (int i = 0; i < 16; i++)
         order[i] = i;
      for (int i = 15; i > 0; i--) begin
         j        = $urandom_range(0, i);
         tmp      = order[i];
         order[i] = order[j];
         order[j] = tmp;
      end
      for (int i = 0; i < n; i++) begin
         pos     = order[i];
         e.start = (i == 0) && first_start;
         e.row   = 2'(pos >> 2);
         e.col   = 2'(pos & 3);
         e.value = rand_q16();
         e.last  = ends && (i == n - 1);
         send_request(e, 1'b0, ST_OK);
      end
   endtask

   task automatic set_idling(input int mode);
      case (mode)
         0: begin send_idle_pct = 0;  stall_pct = 0;  end
         1: begin send_idle_pct = 57; stall_pct = 0;  end
         2: begin send_idle_pct = 0;  stall_pct = 57; end
         default: begin send_idle_pct = 15; stall_pct = 15; end
      endcase
   endtask

   // response side: check each accepted response, then pick the next ready
   always @(posedge clock) begin
      model_elem_type want;
      model_elem_type seen;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen.bone   = rsp_tdata[7:0];
         seen.row    = rsp_tdata[9:8];
         seen.col    = rsp_tdata[11:10];
         seen.value  = rsp_tdata[43:12];
         seen.status = status_type'(rsp_tuser);
         seen.last   = rsp_tlast;
         n_responses++;
         if (seen.status != ST_OK)
            n_err_resp++;
         if (model_elems_due.size() == 0) begin
            log_error($sformatf("response with nothing pending: bone %0d r%0d c%0d %h st %0d",
                                seen.bone, seen.row, seen.col, seen.value, seen.status));
         end else begin
            want = model_elems_due.pop_front();
            if (seen.bone !== want.bone || seen.row !== want.row || seen.col !== want.col ||
                seen.value !== want.value || seen.status !== want.status ||
                seen.last !== want.last)
               log_error($sformatf({"mismatch: want bone %0d r%0d c%0d %h st %0d last %0b,",
                                    " got bone %0d r%0d c%0d %h st %0d last %0b"},
                                   want.bone, want.row, want.col, want.value, want.status,
                                   want.last, seen.bone, seen.row, seen.col, seen.value,
                                   seen.status, seen.last));
         end
      end
      rsp_tready <= !reset && ($urandom_range(0, 99) >= stall_pct);
   end

   initial begin
      bone_elem_type e;
      int phase_start;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed plan, no idling
      set_idling(0);
      foreach (plan[i]) begin
         if (plan[i].cfg >= 0) begin
            drain_results(DRAIN_CYCLES);
            write_bone_count(plan[i].cfg);
         end
         e.start   = plan[i].start;
         e.bone    = 8'(plan[i].bone);
         e.has_par = plan[i].has_par;
         e.par     = 8'(plan[i].par);
         e.row     = 2'(plan[i].pos >> 2);
         e.col     = 2'(plan[i].pos & 3);
         e.value   = plan[i].value;
         e.last    = plan[i].last;
         send_request(e, plan[i].typed, plan[i].want);
      end

      // random phases: each with its own skeleton size and idling pattern
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         drain_results(DRAIN_CYCLES);
         write_bone_count(PHASE_COUNTS[ph]);
         set_idling(ph % 4);
         phase_start = n_requests;
         while (n_requests - phase_start < PHASE_ITEMS)
            random_bone();
      end

      drain_results(END_CYCLES);
      if (model_elems_due.size() != 0)
         log_error($sformatf("%0d responses never arrived", model_elems_due.size()));

      $display("run: %0d requests over %0d bones, %0d responses (%0d error status),",
               n_requests, bones_sent, n_responses, n_err_resp);
      $display("     %0d bone_count settings, %0d failures", n_settings, errors);
      if (errors == 0)
         $display("tb_skeleton_model_transform_chain: clean");
      else
         $display("tb_skeleton_model_transform_chain: errors");
      $finish;
   end

endmodule

// ===== sim.f =====
design/smtc_pkg.sv
design/smtc_ctrl.sv
design/smtc_datapath.sv
design/skeleton_model_transform_chain.sv
design/smtc_checker.sv
bench/tb_skeleton_model_transform_chain.sv
